@@ hdl/stm_pkg.sv @@
package stm_pkg;

	localparam int unsigned KindW   = 2;
	localparam int unsigned SampleW = 8;
	localparam int unsigned PosW    = 16;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned DwellW  = 8;
	localparam int unsigned LockW   = 4;
	localparam int unsigned PhaseW  = 2;
	localparam int unsigned ProdW   = SampleW + PosW;
	localparam int unsigned PaddrW  = 4;
	localparam int unsigned PdataW  = 32;

	localparam logic [KindW-1:0] KindButton  = 2'd0;
	localparam logic [KindW-1:0] KindLockout = 2'd1;
	localparam logic [KindW-1:0] KindTick    = 2'd2;

	localparam logic [ModeW-1:0] ModeKnob   = 2'd0;
	localparam logic [ModeW-1:0] ModeCenter = 2'd1;
	localparam logic [ModeW-1:0] ModeSweep  = 2'd2;

	localparam logic [PhaseW-1:0] PhaseRise   = 2'd0;
	localparam logic [PhaseW-1:0] PhaseTop    = 2'd1;
	localparam logic [PhaseW-1:0] PhaseFall   = 2'd2;
	localparam logic [PhaseW-1:0] PhaseBottom = 2'd3;

	localparam logic [1:0] RegMinPos    = 2'd0;
	localparam logic [1:0] RegMaxPos    = 2'd1;
	localparam logic [1:0] RegCenterPos = 2'd2;
	localparam logic [1:0] RegDwellMs   = 2'd3;

	localparam logic [PosW-1:0]   MinPosReset    = 16'd1000;
	localparam logic [PosW-1:0]   MaxPosReset    = 16'd2000;
	localparam logic [PosW-1:0]   CenterPosReset = 16'd1500;
	localparam logic [DwellW-1:0] DwellReset     = 8'd150;

	localparam logic [SampleW-1:0] AdcLow  = 8'd0;
	localparam logic [SampleW-1:0] AdcHigh = 8'd255;
	localparam logic [LockW:0]     LockoutLimit = 5'd10;

	// exact quotient for any product below Span * 2^PosW
	localparam int unsigned RecipShift = 32;
	localparam longint unsigned Span = longint'(AdcHigh) - longint'(AdcLow);
	localparam logic [RecipShift:0] KnobRecip =
		(RecipShift+1)'(((64'd1 << RecipShift) + Span - 64'd1) / Span);

	typedef struct packed {
		logic [PosW-1:0]   min_pos;
		logic [PosW-1:0]   max_pos;
		logic [PosW-1:0]   center_pos;
		logic [DwellW-1:0] dwell_ms;
	} stm_cfg_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ProdW-1:0] prod;
	} stm_stage_t;

endpackage

@@ hdl/stm_in_if.sv @@
interface stm_in_if;
	logic                          valid;
	logic                          ready;
	logic [stm_pkg::KindW-1:0]     kind;
	logic [stm_pkg::SampleW-1:0]   adc_sample;

	modport source(output valid, kind, adc_sample, input ready);
	modport sink(input valid, kind, adc_sample, output ready);
endinterface

@@ hdl/stm_out_if.sv @@
interface stm_out_if;
	logic                       valid;
	logic                       ready;
	logic [stm_pkg::PosW-1:0]   position;
	logic [stm_pkg::ModeW-1:0]  mode;

	modport source(output valid, position, mode, input ready);
	modport sink(input valid, position, mode, output ready);
endinterface

@@ hdl/stm_cfg_regs.sv @@
module stm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stm_pkg::PaddrW-1:0]  paddr,
	input  logic [stm_pkg::PdataW-1:0]  pwdata,
	output logic [stm_pkg::PdataW-1:0]  prdata,
	output logic                        pready,
	output stm_pkg::stm_cfg_t           cfg
);

	stm_pkg::stm_cfg_t cfg_q;
	logic              wr_en;
	logic [1:0]        reg_sel;

	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pos    <= stm_pkg::MinPosReset;
			cfg_q.max_pos    <= stm_pkg::MaxPosReset;
			cfg_q.center_pos <= stm_pkg::CenterPosReset;
			cfg_q.dwell_ms   <= stm_pkg::DwellReset;
		end else if (wr_en) begin
			case (reg_sel)
				stm_pkg::RegMinPos:    cfg_q.min_pos    <= pwdata[stm_pkg::PosW-1:0];
				stm_pkg::RegMaxPos:    cfg_q.max_pos    <= pwdata[stm_pkg::PosW-1:0];
				stm_pkg::RegCenterPos: cfg_q.center_pos <= pwdata[stm_pkg::PosW-1:0];
				stm_pkg::RegDwellMs:   cfg_q.dwell_ms   <= pwdata[stm_pkg::DwellW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			stm_pkg::RegMinPos:    prdata = stm_pkg::PdataW'(cfg_q.min_pos);
			stm_pkg::RegMaxPos:    prdata = stm_pkg::PdataW'(cfg_q.max_pos);
			stm_pkg::RegCenterPos: prdata = stm_pkg::PdataW'(cfg_q.center_pos);
			stm_pkg::RegDwellMs:   prdata = stm_pkg::PdataW'(cfg_q.dwell_ms);
			default:               prdata = '0;
		endcase
	end

endmodule

@@ hdl/stm_knob_front.sv @@
module stm_knob_front (
	input  logic               clk,
	input  logic               arst_n,
	stm_in_if.sink             items,
	input  stm_pkg::stm_cfg_t  cfg,
	output stm_pkg::stm_stage_t stage_s2,
	output logic               valid_s2,
	input  logic               core_ready
);

	logic                          valid_s1;
	logic [stm_pkg::KindW-1:0]     kind_s1;
	logic [stm_pkg::SampleW-1:0]   sample_s1;
	logic                          ready_s1;
	logic                          ready_s2;
	logic [stm_pkg::SampleW-1:0]   clamped;
	logic [stm_pkg::SampleW-1:0]   offset;
	logic [stm_pkg::PosW-1:0]      span_pos;

	assign ready_s2    = !valid_s2 || core_ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign items.ready = ready_s1;

	always_comb begin
		if (sample_s1 < stm_pkg::AdcLow) begin
			clamped = stm_pkg::AdcLow;
		end else if (sample_s1 > stm_pkg::AdcHigh) begin
			clamped = stm_pkg::AdcHigh;
		end else begin
			clamped = sample_s1;
		end
		offset = clamped - stm_pkg::AdcLow;
		// inverted range gives a zero span, so the map lands on min_pos
		if (cfg.max_pos < cfg.min_pos) begin
			span_pos = '0;
		end else begin
			span_pos = cfg.max_pos - cfg.min_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= items.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && items.valid) begin
			kind_s1   <= items.kind;
			sample_s1 <= items.adc_sample;
		end
		if (ready_s2 && valid_s1) begin
			stage_s2.kind <= kind_s1;
			stage_s2.prod <= stm_pkg::ProdW'(offset) * stm_pkg::ProdW'(span_pos);
		end
	end

endmodule

@@ hdl/stm_core.sv @@
module stm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  stm_pkg::stm_cfg_t   cfg,
	input  stm_pkg::stm_stage_t stage_s2,
	input  logic                valid_s2,
	output logic                core_ready,
	stm_out_if.source           results
);

	localparam int unsigned MulW = stm_pkg::ProdW + stm_pkg::RecipShift + 1;

	logic                          out_valid_q;
	logic [stm_pkg::ModeW-1:0]     mode_q,   mode_d;
	logic                          btn_ready_q, btn_ready_d;
	logic [stm_pkg::LockW-1:0]     lock_q,   lock_d;
	logic [stm_pkg::PosW-1:0]      spos_q,   spos_d;
	logic [stm_pkg::PhaseW-1:0]    phase_q,  phase_d;
	logic [stm_pkg::DwellW-1:0]    dcnt_q,   dcnt_d;
	logic [stm_pkg::PosW-1:0]      drive_q,  drive_d;
	logic [stm_pkg::LockW:0]       lock_next;
	logic [stm_pkg::DwellW-1:0]    dcnt_inc;
	logic [MulW-1:0]               quot_full;
	logic [stm_pkg::PosW-1:0]      knob_pos;
	logic                          fire;

	assign core_ready       = !out_valid_q || results.ready;
	assign fire             = valid_s2 && core_ready;
	assign results.valid    = out_valid_q;
	assign results.position = drive_q;
	assign results.mode     = mode_q;

	assign quot_full = MulW'(stage_s2.prod) * MulW'(stm_pkg::KnobRecip);
	assign knob_pos  = quot_full[stm_pkg::RecipShift +: stm_pkg::PosW] + cfg.min_pos;
	assign lock_next = {1'b0, lock_q} + 5'd1;
	assign dcnt_inc  = dcnt_q + 8'd1;

	always_comb begin
		mode_d      = mode_q;
		btn_ready_d = btn_ready_q;
		lock_d      = lock_q;
		spos_d      = spos_q;
		phase_d     = phase_q;
		dcnt_d      = dcnt_q;
		drive_d     = drive_q;
		case (stage_s2.kind)
			stm_pkg::KindButton: begin
				if (btn_ready_q) begin
					btn_ready_d = 1'b0;
					lock_d      = '0;
					mode_d = (mode_q >= stm_pkg::ModeSweep) ? stm_pkg::ModeKnob
						: mode_q + 2'd1;
					if (mode_d == stm_pkg::ModeSweep) begin
						spos_d  = cfg.min_pos;
						phase_d = stm_pkg::PhaseRise;
						dcnt_d  = '0;
					end
				end
			end
			stm_pkg::KindLockout: begin
				if (!btn_ready_q) begin
					if (lock_next > stm_pkg::LockoutLimit) begin
						lock_d      = '0;
						btn_ready_d = 1'b1;
					end else begin
						lock_d = lock_next[stm_pkg::LockW-1:0];
					end
				end
			end
			stm_pkg::KindTick: begin
				case (mode_q)
					stm_pkg::ModeKnob:   drive_d = knob_pos;
					stm_pkg::ModeCenter: drive_d = cfg.center_pos;
					default: begin
						case (phase_q)
							stm_pkg::PhaseRise: begin
								drive_d = spos_q;
								if (spos_q >= cfg.max_pos) begin
									dcnt_d = '0;
									if (cfg.dwell_ms == '0) begin
										phase_d = stm_pkg::PhaseFall;
										spos_d  = cfg.max_pos;
									end else begin
										phase_d = stm_pkg::PhaseTop;
									end
								end else begin
									spos_d = spos_q + 16'd1;
								end
							end
							stm_pkg::PhaseFall: begin
								drive_d = spos_q;
								if (spos_q <= cfg.min_pos) begin
									dcnt_d = '0;
									if (cfg.dwell_ms == '0) begin
										phase_d = stm_pkg::PhaseRise;
										spos_d  = cfg.min_pos;
									end else begin
										phase_d = stm_pkg::PhaseBottom;
									end
								end else begin
									spos_d = spos_q - 16'd1;
								end
							end
							default: begin
								dcnt_d = dcnt_inc;
								if (dcnt_inc >= cfg.dwell_ms) begin
									dcnt_d = '0;
									if (phase_q == stm_pkg::PhaseTop) begin
										phase_d = stm_pkg::PhaseFall;
										spos_d  = cfg.max_pos;
									end else begin
										phase_d = stm_pkg::PhaseRise;
										spos_d  = cfg.min_pos;
									end
								end
							end
						endcase
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q      <= stm_pkg::ModeKnob;
			btn_ready_q <= 1'b1;
			lock_q      <= '0;
			spos_q      <= stm_pkg::MinPosReset;
			phase_q     <= stm_pkg::PhaseRise;
			dcnt_q      <= '0;
			drive_q     <= '0;
		end else begin
			if (core_ready) begin
				out_valid_q <= valid_s2;
			end
			if (fire) begin
				mode_q      <= mode_d;
				btn_ready_q <= btn_ready_d;
				lock_q      <= lock_d;
				spos_q      <= spos_d;
				phase_q     <= phase_d;
				dcnt_q      <= dcnt_d;
				drive_q     <= drive_d;
			end
		end
	end

endmodule

@@ hdl/servo_tester_mode_controller.sv @@
// channel   dir  handshake     payload
// items     in   valid/ready   kind[1:0], adc_sample[7:0]
// results   out  valid/ready   position[15:0], mode[1:0]
// apb       in   psel/penable  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One beat in, one beat out; each beat passes the stage-one, stage-two and result
// registers, and one beat a cycle is sustained while the result side is ready.
// Stage one registers the beat and forms the knob product, stage two divides by
// the ADC span (reciprocal multiply) and updates mode and sweep state.
// The state registers double as the result register.
// arst_n clears all control state and loads the register reset values.
// A stalled result holds; beats keep entering until both stages are full.
module servo_tester_mode_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	stm_in_if.sink                      items,
	stm_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stm_pkg::PaddrW-1:0]  paddr,
	input  logic [stm_pkg::PdataW-1:0]  pwdata,
	output logic [stm_pkg::PdataW-1:0]  prdata,
	output logic                        pready
);

	stm_pkg::stm_cfg_t   cfg;
	stm_pkg::stm_stage_t stage_s2;
	logic                valid_s2;
	logic                core_ready;

	stm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	stm_knob_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg),
		.stage_s2   (stage_s2),
		.valid_s2   (valid_s2),
		.core_ready (core_ready)
	);

	stm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.stage_s2   (stage_s2),
		.valid_s2   (valid_s2),
		.core_ready (core_ready),
		.results    (results)
	);

endmodule

@@ tb/servo_tester_mode_watch.sv @@
`timescale 1ns / 100ps

module servo_tester_mode_watch (
	input  logic                        clk,
	input  logic                        arst_n,
	stm_in_if                           items,
	stm_out_if                          results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [stm_pkg::PaddrW-1:0]  paddr,
	input  logic [stm_pkg::PdataW-1:0]  pwdata,
	output int                          errors,
	output int                          pending
);

	typedef struct packed {
		logic [stm_pkg::ModeW-1:0]  mode;
		logic                       ready;
		logic [stm_pkg::LockW-1:0]  lock;
		logic [stm_pkg::PosW-1:0]   sweep;
		logic [stm_pkg::PhaseW-1:0] phase;
		logic [stm_pkg::DwellW-1:0] dwell;
		logic [stm_pkg::PosW-1:0]   drive;
	} servo_state_t;

	typedef struct packed {
		logic [stm_pkg::PosW-1:0]  position;
		logic [stm_pkg::ModeW-1:0] mode;
	} servo_beat_t;

	servo_state_t      ctl;
	stm_pkg::stm_cfg_t cfg;
	servo_beat_t       drive_queue[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	function automatic logic [stm_pkg::PosW-1:0] knob_position(stm_pkg::stm_cfg_t c,
			logic [stm_pkg::SampleW-1:0] sample);
		logic [31:0] a;
		logic [31:0] span;
		logic [31:0] prod;
		if (stm_pkg::AdcHigh <= stm_pkg::AdcLow || c.max_pos < c.min_pos)
			return c.min_pos;
		a = 32'(sample);
		if (a < 32'(stm_pkg::AdcLow))
			a = 32'(stm_pkg::AdcLow);
		if (a > 32'(stm_pkg::AdcHigh))
			a = 32'(stm_pkg::AdcHigh);
		span = 32'(c.max_pos) - 32'(c.min_pos);
		prod = (a - 32'(stm_pkg::AdcLow)) * span;
		return stm_pkg::PosW'(prod / (32'(stm_pkg::AdcHigh) - 32'(stm_pkg::AdcLow))
			+ 32'(c.min_pos));
	endfunction

	function automatic servo_state_t ramp_end(servo_state_t st, stm_pkg::stm_cfg_t c,
			logic [stm_pkg::PhaseW-1:0] hold_phase, logic [stm_pkg::PhaseW-1:0] next_phase);
		st.dwell = '0;
		if (c.dwell_ms == '0) begin
			st.phase = next_phase;
			st.sweep = (next_phase == stm_pkg::PhaseFall) ? c.max_pos : c.min_pos;
		end else begin
			st.phase = hold_phase;
		end
		return st;
	endfunction

	function automatic servo_state_t sweep_step(servo_state_t st, stm_pkg::stm_cfg_t c);
		case (st.phase)
			stm_pkg::PhaseRise: begin
				st.drive = st.sweep;
				if (st.sweep >= c.max_pos)
					st = ramp_end(st, c, stm_pkg::PhaseTop, stm_pkg::PhaseFall);
				else
					st.sweep = st.sweep + 16'd1;
			end
			stm_pkg::PhaseFall: begin
				st.drive = st.sweep;
				if (st.sweep <= c.min_pos)
					st = ramp_end(st, c, stm_pkg::PhaseBottom, stm_pkg::PhaseRise);
				else
					st.sweep = st.sweep - 16'd1;
			end
			default: begin
				st.dwell = st.dwell + 8'd1;
				if (st.dwell >= c.dwell_ms) begin
					st.dwell = '0;
					if (st.phase == stm_pkg::PhaseTop) begin
						st.phase = stm_pkg::PhaseFall;
						st.sweep = c.max_pos;
					end else begin
						st.phase = stm_pkg::PhaseRise;
						st.sweep = c.min_pos;
					end
				end
			end
		endcase
		return st;
	endfunction

	function automatic servo_state_t step_controller(servo_state_t st, stm_pkg::stm_cfg_t c,
			logic [stm_pkg::KindW-1:0] kind, logic [stm_pkg::SampleW-1:0] sample);
		logic [stm_pkg::LockW:0] next_lock;
		case (kind)
			stm_pkg::KindButton: begin
				if (st.ready) begin
					st.ready = 1'b0;
					st.lock  = '0;
					st.mode  = (st.mode >= stm_pkg::ModeSweep) ? stm_pkg::ModeKnob
						: st.mode + 2'd1;
					if (st.mode == stm_pkg::ModeSweep) begin
						st.sweep = c.min_pos;
						st.phase = stm_pkg::PhaseRise;
						st.dwell = '0;
					end
				end
			end
			stm_pkg::KindLockout: begin
				if (!st.ready) begin
					next_lock = {1'b0, st.lock} + 5'd1;
					if (next_lock > stm_pkg::LockoutLimit) begin
						st.lock  = '0;
						st.ready = 1'b1;
					end else begin
						st.lock = next_lock[stm_pkg::LockW-1:0];
					end
				end
			end
			stm_pkg::KindTick: begin
				case (st.mode)
					stm_pkg::ModeKnob:   st.drive = knob_position(c, sample);
					stm_pkg::ModeCenter: st.drive = c.center_pos;
					default:             st = sweep_step(st, c);
				endcase
			end
			default: ;
		endcase
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		servo_beat_t head;
		servo_beat_t beat;
		if (!arst_n) begin
			cfg.min_pos    = stm_pkg::MinPosReset;
			cfg.max_pos    = stm_pkg::MaxPosReset;
			cfg.center_pos = stm_pkg::CenterPosReset;
			cfg.dwell_ms   = stm_pkg::DwellReset;
			ctl.mode  = stm_pkg::ModeKnob;
			ctl.ready = 1'b1;
			ctl.lock  = '0;
			ctl.sweep = stm_pkg::MinPosReset;
			ctl.phase = stm_pkg::PhaseRise;
			ctl.dwell = '0;
			ctl.drive = '0;
			drive_queue.delete();
		end else begin
			if (results.valid && results.ready) begin
				if (drive_queue.size() == 0) begin
					report_mismatch("result beat with none due, position", results.position, 0);
				end else begin
					head = drive_queue.pop_front();
					if (results.position !== head.position)
						report_mismatch("position", results.position, head.position);
					if (results.mode !== head.mode)
						report_mismatch("mode", results.mode, head.mode);
				end
			end
			if (items.valid && items.ready) begin
				ctl = step_controller(ctl, cfg, items.kind, items.adc_sample);
				beat.position = ctl.drive;
				beat.mode     = ctl.mode;
				drive_queue.push_back(beat);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[stm_pkg::PaddrW-1:2])
					stm_pkg::RegMinPos:    cfg.min_pos    = pwdata[stm_pkg::PosW-1:0];
					stm_pkg::RegMaxPos:    cfg.max_pos    = pwdata[stm_pkg::PosW-1:0];
					stm_pkg::RegCenterPos: cfg.center_pos = pwdata[stm_pkg::PosW-1:0];
					stm_pkg::RegDwellMs:   cfg.dwell_ms   = pwdata[stm_pkg::DwellW-1:0];
					default: ;
				endcase
			end
		end
		pending = drive_queue.size();
	end

endmodule

@@ tb/servo_tester_mode_controller_test.sv @@
`timescale 1ns / 100ps

module servo_tester_mode_controller_test;

	localparam logic [stm_pkg::KindW-1:0] KindSpare = 2'd3;
	localparam int Phases        = 8;
	localparam int ItemsPerPhase = 130;
	localparam int HoldCycles    = 80;
	localparam int SettleCycles  = 8;
	localparam int CycleLimit    = 200000;

	logic                       clk     = 1'b0;
	logic                       arst_n  = 1'b0;
	logic                       psel    = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite  = 1'b0;
	logic [stm_pkg::PaddrW-1:0] paddr   = '0;
	logic [stm_pkg::PdataW-1:0] pwdata  = '0;
	logic [stm_pkg::PdataW-1:0] prdata;
	logic                       pready;

	int errors;
	int pending;
	int idle_pct;
	int stall_pct;
	int hold_reqs;
	int cycle_count;

	stm_in_if  items_if();
	stm_out_if results_if();

	servo_tester_mode_controller u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	servo_tester_mode_watch u_watch (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CycleLimit);
		$display("servo_tester_mode_controller_test: errors");
		$finish;
	end

	// result side: random stall, or a long hold-off on request
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input logic [stm_pkg::KindW-1:0] kind,
			input logic [stm_pkg::SampleW-1:0] sample);
		while ($urandom_range(99) < idle_pct) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid      <= 1'b1;
		items_if.kind       <= kind;
		items_if.adc_sample <= sample;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [stm_pkg::PdataW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_setting(input int p);
		stm_pkg::stm_cfg_t c;
		c.min_pos    = stm_pkg::MinPosReset;
		c.max_pos    = stm_pkg::MaxPosReset;
		c.center_pos = stm_pkg::CenterPosReset;
		c.dwell_ms   = stm_pkg::DwellReset;
		case (p)
			1: c = {16'd100, 16'd110, 16'd0, 8'd3};
			2: c = {16'd1, 16'd65535, 16'd65535, 8'd0};
			3: c = {16'd65535, 16'd65535, 16'd1234, 8'd255};
			4: c = {16'd500, 16'd100, 16'd777, 8'd1};      // max below min
			5: c = {16'd200, 16'd203, 16'd42, 8'd0};
			6: begin
				c.min_pos    = stm_pkg::PosW'($urandom_range(65500, 1));
				c.max_pos    = c.min_pos + stm_pkg::PosW'($urandom_range(20));
				c.center_pos = stm_pkg::PosW'($urandom_range(65535));
				c.dwell_ms   = stm_pkg::DwellW'($urandom_range(5));
			end
			7: c = {16'd1, 16'd4, 16'd65535, 8'd2};
			default: ;
		endcase
		reg_write(stm_pkg::RegMinPos, stm_pkg::PdataW'(c.min_pos));
		reg_write(stm_pkg::RegMaxPos, stm_pkg::PdataW'(c.max_pos));
		reg_write(stm_pkg::RegCenterPos, stm_pkg::PdataW'(c.center_pos));
		reg_write(stm_pkg::RegDwellMs, stm_pkg::PdataW'(c.dwell_ms));
	endtask

	function automatic logic [stm_pkg::SampleW-1:0] pick_sample();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? stm_pkg::AdcHigh : stm_pkg::AdcLow;
		return stm_pkg::SampleW'($urandom_range(255));
	endfunction

	// press, then enough lockout ticks to release it
	task automatic press_and_release();
		send_item(stm_pkg::KindButton, pick_sample());
		repeat (int'(stm_pkg::LockoutLimit) + 1)
			send_item(stm_pkg::KindLockout, pick_sample());
	endtask

	task automatic random_item();
		int r;
		logic [stm_pkg::KindW-1:0] k;
		r = $urandom_range(99);
		if (r < 8)
			k = stm_pkg::KindButton;
		else if (r < 30)
			k = stm_pkg::KindLockout;
		else if (r < 95)
			k = stm_pkg::KindTick;
		else
			k = KindSpare;
		send_item(k, pick_sample());
	endtask

	initial begin : stimulus
		items_if.valid      = 1'b0;
		items_if.kind       = stm_pkg::KindButton;
		items_if.adc_sample = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_reqs = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		send_item(stm_pkg::KindTick, stm_pkg::AdcLow);
		send_item(stm_pkg::KindTick, stm_pkg::AdcHigh);
		send_item(stm_pkg::KindTick, 8'h55);
		send_item(KindSpare, 8'hAA);
		send_item(stm_pkg::KindLockout, 8'h00);        // no lockout running
		send_item(stm_pkg::KindButton, 8'h00);
		send_item(stm_pkg::KindButton, 8'hFF);         // inside lockout
		send_item(stm_pkg::KindTick, 8'h80);
		repeat (int'(stm_pkg::LockoutLimit) + 1)
			send_item(stm_pkg::KindLockout, 8'h00);
		send_item(stm_pkg::KindButton, 8'h00);
		send_item(stm_pkg::KindTick, 8'h00);
		send_item(stm_pkg::KindTick, 8'h00);
		drain();

		for (int p = 0; p < Phases; p++) begin
			if (p > 0)
				apply_setting(p);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 74; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 74; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			for (int n = 0; n < ItemsPerPhase; n++) begin
				if (p % 4 == 0 && n == 40)
					hold_reqs++;
				if ($urandom_range(99) < 4)
					press_and_release();
				else
					random_item();
			end
			drain();
		end

		repeat (SettleCycles) @(posedge clk);
		if (errors == 0)
			$display("servo_tester_mode_controller_test: clean");
		else
			$display("servo_tester_mode_controller_test: errors");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/stm_pkg.sv
hdl/stm_in_if.sv
hdl/stm_out_if.sv
hdl/stm_cfg_regs.sv
hdl/stm_knob_front.sv
hdl/stm_core.sv
hdl/servo_tester_mode_controller.sv
tb/servo_tester_mode_watch.sv
tb/servo_tester_mode_controller_test.sv
